[hdl/wlm_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the wildcard matcher.
package wlm_pkg;

  localparam int PATTERN_DEPTH = 64;
  localparam int SUBJECT_DEPTH = 64;
  localparam int CHAR_BITS     = 8;
  localparam int SYMBOL_BITS   = 8;
  localparam int OP_BITS       = 2;
  localparam int CFG_IDX_BITS  = 1;

  localparam int P_LEN_BITS  = $clog2(PATTERN_DEPTH + 1);
  localparam int S_LEN_BITS  = $clog2(SUBJECT_DEPTH + 1);
  localparam int P_ADDR_BITS = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int S_ADDR_BITS = (SUBJECT_DEPTH > 1) ? $clog2(SUBJECT_DEPTH) : 1;

  localparam logic [OP_BITS-1:0] OP_APPEND_PAT = 2'd0;
  localparam logic [OP_BITS-1:0] OP_APPEND_SUB = 2'd1;
  localparam logic [OP_BITS-1:0] OP_EVALUATE   = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_ANY_ONE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ANY_RUN = 1'b1;

  localparam logic [SYMBOL_BITS-1:0] ANY_ONE_RESET = 8'd95;
  localparam logic [SYMBOL_BITS-1:0] ANY_RUN_RESET = 8'd37;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_RUN     = 2'd1,
    ACT_ADV     = 2'd2,
    ACT_RESTART = 2'd3
  } wlm_act_t;

  typedef struct packed {
    logic     append_pat;
    logic     append_sub;
    logic     init;
    logic     read;
    wlm_act_t act;
    logic     finish;
    logic     match_bit;
  } wlm_cmd_t;

  typedef struct packed {
    logic sub_left;
    logic pat_left;
    logic pc_run;
    logic pc_hit;
    logic can_restart;
    logic overflow;
  } wlm_status_t;

endpackage

[hdl/wildcard_like_matcher_top.sv]
// Top level of the wildcard matcher: controller, datapath and configuration port.
// Append transactions are taken while idle and may arrive back to back.
// Evaluate holds busy through each match step (store read in S_CHECK, then compare in S_MATCH),
// then through S_TAIL_CHECK (and S_TAIL for trailing run symbols) for the final pattern check;
// restarts allow up to about (subject_length + 1) * (pattern_length + 1) steps. The result strobe
// rises as busy falls; with overflow set busy stays low and the strobe comes in the next cycle.
// Synchronous reset clears lengths, overflow and controller state and restores both symbols.
module wildcard_like_matcher_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [wlm_pkg::OP_BITS-1:0]      operation,
  input  logic [wlm_pkg::SYMBOL_BITS-1:0]  symbol,
  output logic                             done,
  output logic                             matched,
  output logic                             overflow,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wlm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [wlm_pkg::SYMBOL_BITS-1:0]  cfg_data
);
  import wlm_pkg::*;

  wlm_cmd_t    cmd;
  wlm_status_t status;

  assign cfg_ready = 1'b1;

  wlm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  wlm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .symbol    (symbol),
    .cfg_write (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .done      (done),
    .matched   (matched),
    .overflow  (overflow)
  );

endmodule

[hdl/wlm_datapath.sv]
// Datapath: character stores, lengths, match pointers, configuration and result registers.
module wlm_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  wlm_pkg::wlm_cmd_t                cmd,
  input  logic [wlm_pkg::SYMBOL_BITS-1:0]  symbol,
  input  logic                             cfg_write,
  input  logic [wlm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [wlm_pkg::SYMBOL_BITS-1:0]  cfg_data,
  output wlm_pkg::wlm_status_t             status,
  output logic                             done,
  output logic                             matched,
  output logic                             overflow
);
  import wlm_pkg::*;

  logic [CHAR_BITS-1:0]  pat_mem [PATTERN_DEPTH];
  logic [CHAR_BITS-1:0]  sub_mem [SUBJECT_DEPTH];
  logic [CHAR_BITS-1:0]  pc;
  logic [CHAR_BITS-1:0]  sc;
  logic [CHAR_BITS-1:0]  any_one;
  logic [CHAR_BITS-1:0]  any_run;
  logic [P_LEN_BITS-1:0] plen;
  logic [S_LEN_BITS-1:0] slen;
  logic [P_LEN_BITS-1:0] pp;
  logic [S_LEN_BITS-1:0] sp;
  logic [P_LEN_BITS-1:0] rp;
  logic [S_LEN_BITS-1:0] rs;
  logic                  restart_ok;
  logic                  ovf;
  logic                  pat_full;
  logic                  sub_full;
  logic [CHAR_BITS-1:0]  ch;

  assign ch       = symbol[CHAR_BITS-1:0];
  assign pat_full = (plen == P_LEN_BITS'(PATTERN_DEPTH));
  assign sub_full = (slen == S_LEN_BITS'(SUBJECT_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.append_pat && !pat_full) begin
      pat_mem[plen[P_ADDR_BITS-1:0]] <= ch;
    end
    if (cmd.append_sub && !sub_full) begin
      sub_mem[slen[S_ADDR_BITS-1:0]] <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      pc <= pat_mem[pp[P_ADDR_BITS-1:0]];
      sc <= sub_mem[sp[S_ADDR_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_one <= ANY_ONE_RESET[CHAR_BITS-1:0];
      any_run <= ANY_RUN_RESET[CHAR_BITS-1:0];
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ANY_ONE: any_one <= cfg_data[CHAR_BITS-1:0];
        REG_ANY_RUN: any_run <= cfg_data[CHAR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= '0;
      slen <= '0;
      ovf  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        plen <= '0;
        slen <= '0;
        ovf  <= 1'b0;
      end else begin
        if (cmd.append_pat) begin
          if (pat_full) begin
            ovf <= 1'b1;
          end else begin
            plen <= plen + 1'b1;
          end
        end
        if (cmd.append_sub) begin
          if (sub_full) begin
            ovf <= 1'b1;
          end else begin
            slen <= slen + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      matched  <= cmd.match_bit & ~ovf;
      overflow <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      pp         <= '0;
      sp         <= '0;
      rp         <= '0;
      rs         <= '0;
      restart_ok <= 1'b0;
    end else begin
      unique case (cmd.act)
        ACT_RUN: begin
          pp         <= pp + 1'b1;
          rp         <= pp + 1'b1;
          rs         <= sp;
          restart_ok <= 1'b1;
        end
        ACT_ADV: begin
          pp <= pp + 1'b1;
          sp <= sp + 1'b1;
        end
        ACT_RESTART: begin
          pp <= rp;
          rs <= rs + 1'b1;
          sp <= rs + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status.sub_left    = (sp < slen);
    status.pat_left    = (pp < plen);
    status.pc_run      = (pc == any_run);
    status.pc_hit      = (pc == any_one) || (sc == pc);
    status.can_restart = restart_ok;
    status.overflow    = ovf;
  end

endmodule

[hdl/wlm_controller.sv]
// Controller: sequences appends and the greedy match walk with a single restart point.
module wlm_controller (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [wlm_pkg::OP_BITS-1:0] operation,
  input  wlm_pkg::wlm_status_t        status,
  output logic                        busy,
  output wlm_pkg::wlm_cmd_t           cmd
);
  import wlm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE       = 5'b00001,
    S_CHECK      = 5'b00010,
    S_MATCH      = 5'b00100,
    S_TAIL_CHECK = 5'b01000,
    S_TAIL       = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.act    = ACT_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (operation)
            OP_APPEND_PAT: cmd.append_pat = 1'b1;
            OP_APPEND_SUB: cmd.append_sub = 1'b1;
            OP_EVALUATE: begin
              if (status.overflow) begin
                cmd.finish = 1'b1;
              end else begin
                cmd.init   = 1'b1;
                state_next = S_CHECK;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (status.sub_left) begin
          cmd.read   = 1'b1;
          state_next = S_MATCH;
        end else begin
          state_next = S_TAIL_CHECK;
        end
      end
      S_MATCH: begin
        if (status.pat_left && status.pc_run) begin
          cmd.act    = ACT_RUN;
          state_next = S_CHECK;
        end else if (status.pat_left && status.pc_hit) begin
          cmd.act    = ACT_ADV;
          state_next = S_CHECK;
        end else if (status.can_restart) begin
          cmd.act    = ACT_RESTART;
          state_next = S_CHECK;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TAIL_CHECK: begin
        if (status.pat_left) begin
          cmd.read   = 1'b1;
          state_next = S_TAIL;
        end else begin
          cmd.finish    = 1'b1;
          cmd.match_bit = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_TAIL: begin
        if (status.pc_run) begin
          cmd.act    = ACT_RUN;
          state_next = S_TAIL_CHECK;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
